// ----- hw/rtl/grwt_pkg.sv -----
// shared types and constants of the grid ray wall traversal unit
package grwt_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;
    localparam int MAX_STEPS = 100;
    localparam int FRAC_BITS = 16;

    localparam int COORD_W   = 24;
    localparam int DIM_W     = 7;
    localparam int TILE_W    = 6;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam int MAP_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int COL_IDX_W = $clog2(MAX_COLS);
    localparam int ROW_IDX_W = $clog2(MAX_ROWS);

    // internal position width: one guard bit plus headroom past the grid edge
    localparam int S_W       = COORD_W + 2;
    localparam int CELL_W    = S_W - FRAC_BITS;
    localparam int NX_W      = FRAC_BITS + 1;
    localparam int PROD_W    = NX_W + COORD_W;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int DCNT_W    = $clog2(NX_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    localparam logic [KIND_W-1:0] STOP_WALL  = 2'd0;
    localparam logic [KIND_W-1:0] STOP_EXIT  = 2'd1;
    localparam logic [KIND_W-1:0] STOP_LIMIT = 2'd2;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST  = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic [TILE_W-1:0]          tile_col;
        logic [TILE_W-1:0]          tile_row;
        logic                       tile_is_wall;
        logic signed [COORD_W-1:0]  origin_x;
        logic signed [COORD_W-1:0]  origin_y;
        logic signed [COORD_W-1:0]  ray_dx;
        logic signed [COORD_W-1:0]  ray_dy;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  hit_x;
        logic signed [COORD_W-1:0]  hit_y;
        logic [KIND_W-1:0]          stop_kind;
    } out_word_t;

endpackage

// ----- hw/rtl/grwt_in_if.sv -----
// input channel of the grid ray wall traversal unit
interface grwt_in_if import grwt_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/grwt_out_if.sv -----
// result channel of the grid ray wall traversal unit
interface grwt_out_if import grwt_pkg::*; ();
    logic      valid;
    logic      ready;
    out_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/grwt_ram.sv -----
// generic single port ram with registered read
module grwt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end
endmodule

// ----- hw/rtl/grid_ray_wall_traversal_unit.sv -----
// top level: wall map and sequencer for the 2d grid ray walk
// sequence: a cast checks each cell (check, read states) and then steps across
//   it (mula, mulb, decide, div, update states), up to MAX_STEPS steps
// throughput: one word at a time; the shared multiplier and the bit-serial divider
//   set the per-step cost
// reset: asynchronous active low; afterwards a clearing pass writes zero to all
//   MAP_DEPTH (4096) map entries, one a cycle, before the first word is taken
module grid_ray_wall_traversal_unit import grwt_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    grwt_in_if.sink               in_ch,
    grwt_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DIM_W-1:0]      cfg_data
);
    // sequencer codes
    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_CHECK  = 4'd2;
    localparam logic [3:0] ST_READ   = 4'd3;
    localparam logic [3:0] ST_MULA   = 4'd4;
    localparam logic [3:0] ST_MULB   = 4'd5;
    localparam logic [3:0] ST_DECIDE = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_UPDATE = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    // step kinds
    localparam logic [1:0] STEP_X    = 2'd0;
    localparam logic [1:0] STEP_Y    = 2'd1;
    localparam logic [1:0] STEP_BOTH = 2'd2;

    localparam logic signed [S_W-1:0] SAT_HI = S_W'((1 <<< (COORD_W - 1)) - 1);
    localparam logic signed [S_W-1:0] SAT_LO = -S_W'(1 <<< (COORD_W - 1));

    logic [3:0]                 state_reg;
    logic [ADDR_W-1:0]          clr_addr_reg;
    logic [DIM_W-1:0]           grid_width_reg;
    logic [DIM_W-1:0]           grid_height_reg;

    // ray state
    logic signed [S_W-1:0]      sx_reg, sy_reg;
    logic signed [CELL_W-1:0]   cx_reg, cy_reg;
    logic [COORD_W-1:0]         rxm_reg, rym_reg;
    logic                       rx_neg_reg, ry_neg_reg;
    logic signed [S_W-1:0]      bx_reg, by_reg;
    logic [NX_W-1:0]            nx_reg, ny_reg;
    logic [PROD_W-1:0]          a_reg, b_reg;
    logic [1:0]                 kind_reg;
    logic [STEP_W-1:0]          step_cnt_reg;

    // shared divider
    logic [COORD_W-1:0]         rem_reg;
    logic [NX_W-1:0]            quo_reg;
    logic [COORD_W-1:0]         dvs_reg;
    logic [DCNT_W-1:0]          div_cnt_reg;

    // pending result and output register
    logic signed [S_W-1:0]      res_x_reg, res_y_reg;
    logic [KIND_W-1:0]          res_kind_reg;
    logic                       out_valid_reg;
    out_word_t                  out_word_reg;

    // map port
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_addr;
    logic [0:0]                 ram_wdata;
    logic [0:0]                 ram_rdata;

    logic                       in_fire;
    logic                       tile_ok;
    logic [ADDR_W-1:0]          tile_addr;
    logic [ADDR_W-1:0]          cell_addr;
    logic signed [CELL_W-1:0]   w_lim, h_lim, gw_ext, gh_ext;
    logic                       cell_out;
    logic signed [CELL_W-1:0]   cx_plus, cy_plus;
    logic signed [S_W-1:0]      bx_calc, by_calc, dx_diff, dy_diff;
    logic [NX_W-1:0]            mul_op_a;
    logic [COORD_W-1:0]         mul_op_b;
    logic [PROD_W-1:0]          prod;
    logic [1:0]                 kind_calc;
    logic [COORD_W:0]           div_trial;
    logic                       div_take;
    logic signed [S_W-1:0]      step_d;
    logic                       out_free;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_word_reg;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // tile writes beyond the map are dropped
    assign tile_ok = (ADDR_W'(in_ch.payload.tile_col) < ADDR_W'(MAX_COLS))
                  && (ADDR_W'(in_ch.payload.tile_row) < ADDR_W'(MAX_ROWS));
    assign tile_addr = ADDR_W'(ADDR_W'(in_ch.payload.tile_row) * ADDR_W'(MAX_COLS)
                     + ADDR_W'(in_ch.payload.tile_col));
    assign cell_addr = ADDR_W'(ADDR_W'(cy_reg[ROW_IDX_W-1:0]) * ADDR_W'(MAX_COLS)
                     + ADDR_W'(cx_reg[COL_IDX_W-1:0]));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = cell_addr;
        ram_wdata = 1'b0;
        if (state_reg == ST_CLEAR)
        begin
            ram_we   = 1'b1;
            ram_addr = clr_addr_reg;
        end
        else if (in_fire && in_ch.payload.mode == MODE_WRITE && tile_ok)
        begin
            ram_we    = 1'b1;
            ram_addr  = tile_addr;
            ram_wdata = in_ch.payload.tile_is_wall;
        end
    end

    grwt_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // grid size in use, saturated to the map size
    assign gw_ext = CELL_W'(grid_width_reg);
    assign gh_ext = CELL_W'(grid_height_reg);
    assign w_lim  = (gw_ext > CELL_W'(MAX_COLS)) ? CELL_W'(MAX_COLS) : gw_ext;
    assign h_lim  = (gh_ext > CELL_W'(MAX_ROWS)) ? CELL_W'(MAX_ROWS) : gh_ext;
    assign cell_out = cx_reg[CELL_W-1] || cy_reg[CELL_W-1]
                   || (cx_reg >= w_lim) || (cy_reg >= h_lim);

    // next borders and distances to them
    assign cx_plus = cx_reg + (rx_neg_reg ? CELL_W'(0) : CELL_W'(1));
    assign cy_plus = cy_reg + (ry_neg_reg ? CELL_W'(0) : CELL_W'(1));
    assign bx_calc = {cx_plus, {FRAC_BITS{1'b0}}};
    assign by_calc = {cy_plus, {FRAC_BITS{1'b0}}};
    assign dx_diff = bx_calc - sx_reg;
    assign dy_diff = by_calc - sy_reg;

    // shared multiplier: border distance times the other ray magnitude
    assign mul_op_a = (state_reg == ST_MULA) ? nx_reg : ny_reg;
    assign mul_op_b = (state_reg == ST_MULA) ? rym_reg : rxm_reg;
    assign prod     = PROD_W'(mul_op_a) * PROD_W'(mul_op_b);

    always_comb
    begin
        if (rxm_reg == '0 && rym_reg == '0)
        begin
            kind_calc = STEP_BOTH;
        end
        else if (rxm_reg == '0)
        begin
            kind_calc = STEP_Y;
        end
        else if (rym_reg == '0)
        begin
            kind_calc = STEP_X;
        end
        else if (a_reg < b_reg)
        begin
            kind_calc = STEP_X;
        end
        else if (a_reg > b_reg)
        begin
            kind_calc = STEP_Y;
        end
        else
        begin
            kind_calc = STEP_BOTH;
        end
    end

    // one quotient bit a cycle; quotient stays below NX_W bits
    assign div_trial = {rem_reg, quo_reg[NX_W-1]};
    assign div_take  = div_trial >= {1'b0, dvs_reg};
    assign step_d    = S_W'(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            grid_width_reg  <= DIM_W'(64);
            grid_height_reg <= DIM_W'(64);
            out_valid_reg   <= 1'b0;
            step_cnt_reg    <= '0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_GRID_WIDTH)
                begin
                    grid_width_reg <= cfg_data;
                end
                else if (cfg_index == CFG_GRID_HEIGHT)
                begin
                    grid_height_reg <= cfg_data;
                end
            end

            // a new result in the done state refills the register instead
            if (out_valid_reg && out_ch.ready && !(state_reg == ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(MAP_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_fire && in_ch.payload.mode == MODE_CAST)
                    begin
                        sx_reg       <= S_W'(in_ch.payload.origin_x);
                        sy_reg       <= S_W'(in_ch.payload.origin_y);
                        cx_reg       <= CELL_W'(in_ch.payload.origin_x >>> FRAC_BITS);
                        cy_reg       <= CELL_W'(in_ch.payload.origin_y >>> FRAC_BITS);
                        rx_neg_reg   <= in_ch.payload.ray_dx[COORD_W-1];
                        ry_neg_reg   <= in_ch.payload.ray_dy[COORD_W-1];
                        rxm_reg      <= in_ch.payload.ray_dx[COORD_W-1]
                                        ? COORD_W'(-in_ch.payload.ray_dx)
                                        : COORD_W'(in_ch.payload.ray_dx);
                        rym_reg      <= in_ch.payload.ray_dy[COORD_W-1]
                                        ? COORD_W'(-in_ch.payload.ray_dy)
                                        : COORD_W'(in_ch.payload.ray_dy);
                        step_cnt_reg <= '0;
                        state_reg    <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    // map read for this cell is issued this cycle
                    if (step_cnt_reg == STEP_W'(MAX_STEPS))
                    begin
                        res_x_reg    <= '0;
                        res_y_reg    <= '0;
                        res_kind_reg <= STOP_LIMIT;
                        state_reg    <= ST_DONE;
                    end
                    else if (cell_out)
                    begin
                        res_x_reg    <= sx_reg;
                        res_y_reg    <= sy_reg;
                        res_kind_reg <= STOP_EXIT;
                        state_reg    <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (ram_rdata[0])
                    begin
                        res_x_reg    <= sx_reg;
                        res_y_reg    <= sy_reg;
                        res_kind_reg <= STOP_WALL;
                        state_reg    <= ST_DONE;
                    end
                    else
                    begin
                        bx_reg    <= bx_calc;
                        by_reg    <= by_calc;
                        nx_reg    <= NX_W'(dx_diff[S_W-1] ? -dx_diff : dx_diff);
                        ny_reg    <= NX_W'(dy_diff[S_W-1] ? -dy_diff : dy_diff);
                        state_reg <= ST_MULA;
                    end
                end
                ST_MULA:
                begin
                    a_reg     <= prod;
                    state_reg <= ST_MULB;
                end
                ST_MULB:
                begin
                    b_reg     <= prod;
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    kind_reg    <= kind_calc;
                    div_cnt_reg <= '0;
                    if (kind_calc == STEP_X && rym_reg != '0)
                    begin
                        rem_reg   <= a_reg[PROD_W-1:NX_W];
                        quo_reg   <= a_reg[NX_W-1:0];
                        dvs_reg   <= rxm_reg;
                        state_reg <= ST_DIV;
                    end
                    else if (kind_calc == STEP_Y && rxm_reg != '0)
                    begin
                        rem_reg   <= b_reg[PROD_W-1:NX_W];
                        quo_reg   <= b_reg[NX_W-1:0];
                        dvs_reg   <= rym_reg;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        // zero component or a corner hit: no division and no fractional move
                        quo_reg   <= '0;
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_DIV:
                begin
                    rem_reg     <= div_take ? COORD_W'(div_trial - {1'b0, dvs_reg})
                                            : COORD_W'(div_trial);
                    quo_reg     <= {quo_reg[NX_W-2:0], div_take};
                    div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                    if (div_cnt_reg == DCNT_W'(NX_W - 1))
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    case (kind_reg)
                        STEP_X:
                        begin
                            sx_reg <= bx_reg;
                            sy_reg <= ry_neg_reg ? sy_reg - step_d : sy_reg + step_d;
                            cx_reg <= rx_neg_reg ? cx_reg - CELL_W'(1) : cx_reg + CELL_W'(1);
                        end
                        STEP_Y:
                        begin
                            sy_reg <= by_reg;
                            sx_reg <= rx_neg_reg ? sx_reg - step_d : sx_reg + step_d;
                            cy_reg <= ry_neg_reg ? cy_reg - CELL_W'(1) : cy_reg + CELL_W'(1);
                        end
                        default:
                        begin
                            if (rxm_reg != '0)
                            begin
                                sx_reg <= bx_reg;
                            end
                            if (rym_reg != '0)
                            begin
                                sy_reg <= by_reg;
                            end
                            cx_reg <= rx_neg_reg ? cx_reg - CELL_W'(1) : cx_reg + CELL_W'(1);
                            cy_reg <= ry_neg_reg ? cy_reg - CELL_W'(1) : cy_reg + CELL_W'(1);
                        end
                    endcase
                    step_cnt_reg <= step_cnt_reg + STEP_W'(1);
                    state_reg    <= ST_CHECK;
                end
                ST_DONE:
                begin
                    // hand the result to the output register once it is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output word, saturated to the coordinate range
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_word_reg.hit_x <= (res_x_reg > SAT_HI) ? COORD_W'(SAT_HI)
                                : (res_x_reg < SAT_LO) ? COORD_W'(SAT_LO)
                                : COORD_W'(res_x_reg);
            out_word_reg.hit_y <= (res_y_reg > SAT_HI) ? COORD_W'(SAT_HI)
                                : (res_y_reg < SAT_LO) ? COORD_W'(SAT_LO)
                                : COORD_W'(res_y_reg);
            out_word_reg.stop_kind <= res_kind_reg;
        end
    end
endmodule
